// ===== rtl/kalman_angle_filter_macros.svh =====
// Assertion macros shared by the Kalman angle filter RTL.
// Included by modules that carry concurrent checks; depends on nothing else.
`ifndef KALMAN_ANGLE_FILTER_MACROS_SVH
`define KALMAN_ANGLE_FILTER_MACROS_SVH
// implication checked on every clock edge outside reset
`define KAF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked also during reset
`define KAF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/kaf_pkg.sv =====
// Shared types and constants for the Kalman angle filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kaf_pkg;
   localparam int VW = 48;
   localparam int CW = 47;
   localparam int DW = 32;
   localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_SET    = 1'b1;
   localparam logic [1:0] REG_QA = 2'd0;
   localparam logic [1:0] REG_QB = 2'd1;
   localparam logic [1:0] REG_RM = 2'd2;
   typedef logic signed [VW-1:0] val_type;

   // saturate a 50-bit signed sum to 48 bits
   function automatic logic [VW-1:0] sat50(input logic signed [VW+1:0] v);
      logic [VW-1:0] r;
      if (v > $signed({{2{1'b0}}, VMAX})) r = VMAX;
      else if (v < $signed({{2{1'b1}}, VMIN})) r = VMIN;
      else r = v[VW-1:0];
      return r;
   endfunction

   // saturating add/sub of two 48-bit values
   function automatic logic [VW-1:0] addsat(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                           input logic sub);
      logic signed [VW+1:0] ea;
      logic signed [VW+1:0] eb;
      ea = {{2{a[VW-1]}}, a};
      eb = {{2{b[VW-1]}}, b};
      return sat50(sub ? ea - eb : ea + eb);
   endfunction

   // magnitude of a 48-bit signed value
   function automatic logic [VW-1:0] magv(input logic [VW-1:0] v);
      return v[VW-1] ? (~v + VW'(1)) : v;
   endfunction

   // apply sign and cap to a magnitude with an overflow flag
   function automatic logic [VW-1:0] capv(input logic neg, input logic [VW-1:0] m,
                                         input logic ovf);
      logic [VW-1:0] r;
      if (neg) begin
         r = (ovf || m > VMIN) ? VMIN : (~m + VW'(1));
      end else begin
         r = (ovf || m > VMAX) ? VMAX : m;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/kaf_mul.sv =====
// Bit-serial saturating fixed-point multiplier: (a*b) >> sh, rounded.
// Uses kaf_pkg; one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module kaf_mul
   import kaf_pkg::*;
#(
   parameter int SHW = 6
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [VW-1:0]  a,
   input  wire logic [VW-1:0]  b,
   input  wire logic [SHW-1:0] sh,
   output logic                done,
   output logic [VW-1:0]       result
);
   logic [2*VW:0]  acc_ff, acc_in;
   logic [VW-1:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic           busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [SHW-1:0] sh_ff, sh_in;
   logic [2*VW:0]  rnd, shifted;

   always_comb begin
      acc_in = acc_ff; ma_in = ma_ff; mb_in = mb_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; sh_in = sh_ff; done_in = 1'b0;
      if (start) begin
         ma_in = magv(a); mb_in = magv(b); neg_in = a[VW-1] ^ b[VW-1];
         acc_in = '0; cnt_in = '0; busy_in = 1'b1; sh_in = sh;
      end else if (busy_ff) begin
         // shift-add: take multiplier bit from the top down
         acc_in = {acc_ff[2*VW-1:0], 1'b0} + (mb_ff[VW-1] ? {{(VW+1){1'b0}}, ma_ff} : '0);
         mb_in = {mb_ff[VW-2:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(VW-1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   assign rnd = acc_ff + ((2*VW+1)'(1) << (sh_ff - SHW'(1)));
   assign shifted = rnd >> sh_ff;
   assign result = capv(neg_ff, shifted[VW-1:0], |shifted[2*VW:VW]);
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      acc_ff <= acc_in; ma_ff <= ma_in; mb_ff <= mb_in; cnt_ff <= cnt_in;
      neg_ff <= neg_in; sh_ff <= sh_in;
   end
endmodule
`default_nettype wire

// ===== rtl/kaf_div.sv =====
// Bit-serial restoring divider: (n << FRAC) / d, truncated, saturated.
// Uses kaf_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module kaf_div
   import kaf_pkg::*;
#(
   parameter int FRAC_BITS = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [VW-1:0] n,
   input  wire logic [VW-1:0] d,
   output logic               done,
   output logic [VW-1:0]      result
);
   localparam int NB = VW + FRAC_BITS;
   localparam int CB = $clog2(NB + 1);
   logic [NB-1:0] num_ff, num_in;
   logic [VW:0]   rem_ff, rem_in;
   logic [VW-1:0] den_ff, den_in, q_ff, q_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, neg_ff, neg_in, ovf_ff, ovf_in, done_ff, done_in;
   logic [VW:0]   trial;
   logic          qb;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; q_in = q_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; ovf_in = ovf_ff; done_in = 1'b0;
      trial = {rem_ff[VW-1:0], num_ff[NB-1]};
      qb = trial >= {1'b0, den_ff};
      if (start) begin
         num_in = {magv(n), {FRAC_BITS{1'b0}}}; den_in = magv(d);
         neg_in = n[VW-1] ^ d[VW-1]; rem_in = '0; q_in = '0; ovf_in = 1'b0;
         cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qb ? trial - {1'b0, den_ff} : trial;
         num_in = {num_ff[NB-2:0], 1'b0};
         if (!ovf_ff) begin
            q_in = {q_ff[VW-2:0], qb};
            if (q_ff[VW-1] || {q_ff[VW-2:0], qb} > VMIN) ovf_in = 1'b1;
         end
         cnt_in = cnt_ff + CB'(1);
         if (cnt_ff == CB'(NB-1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   assign result = capv(neg_ff, q_ff, ovf_ff);
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in; q_ff <= q_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; ovf_ff <= ovf_in;
   end
endmodule
`default_nettype wire

// ===== rtl/kalman_angle_filter.sv =====
// Two-state Kalman filter for angle and gyro bias, Q16.32 saturating.
// A set item goes straight to the output register; an update runs 10 serial products and
// two divisions, and skips both divisions when S is zero.
// One item at a time; a new beat is taken once the result sits in the output register.
// Synchronous active-high reset clears state and loads default noises.
`timescale 1ns / 1ps
`default_nettype none
module kalman_angle_filter
   import kaf_pkg::*;
#(
   parameter int FRAC_BITS = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   // tdata: measured_angle[47:0], measured_rate[95:48], time_step[127:96]
   input  wire logic [127:0]   req_tdata,
   // tuser: func
   input  wire logic           req_tuser,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   // tdata: filtered_angle[47:0], unbiased_rate[95:48]
   output logic [95:0]         rsp_tdata,
   input  wire logic           csr_we,
   input  wire logic [1:0]     csr_index,
   input  wire logic [CW-1:0]  csr_wdata
);
   `include "kalman_angle_filter_macros.svh"
   localparam logic [CW-1:0] QA_RST = CW'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [CW-1:0] QB_RST = CW'(((64'd3 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [CW-1:0] RM_RST = CW'(((64'd3 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [5:0] SH_DT = 6'(DW);
   localparam logic [5:0] SH_FR = 6'(FRAC_BITS);

   localparam logic [4:0] S_IDLE = 5'd0,  S_M1 = 5'd1,  S_M2 = 5'd2,  S_M3 = 5'd3,
                          S_M4 = 5'd4,  S_M5 = 5'd5,  S_D1 = 5'd6,  S_D2 = 5'd7,
                          S_M6 = 5'd8,  S_M7 = 5'd9,  S_M8 = 5'd10, S_M9 = 5'd11,
                          S_M10 = 5'd12, S_M11 = 5'd13, S_M12 = 5'd14, S_OUT = 5'd15,
                          S_WAITM = 5'd16, S_WAITD = 5'd17;

   logic [CW-1:0] qa_ff, qb_ff, rm_ff;
   logic [VW-1:0] ang_ff, bias_ff, rate_ff, paa_ff, pab_ff, pba_ff, pbb_ff;
   logic [VW-1:0] meas_ff, d_ff, k0_ff, k1_ff, y_ff, p00_ff, p01_ff;
   logic [DW-1:0] dt_ff;
   logic [4:0]    st_ff, ret_ff;
   logic          vld_ff;
   logic [2*VW-1:0] out_ff;
   logic          out_load;
   logic          m_start, m_done, d_start, d_done;
   logic [VW-1:0] m_a, m_b, m_r, d_n, d_d, d_r, s_val, dt_v, t_val;
   logic [5:0]    m_sh;

   assign dt_v = {{(VW-DW){1'b0}}, dt_ff};
   assign s_val = addsat(paa_ff, {1'b0, rm_ff}, 1'b0);
   assign t_val = addsat(addsat(addsat(d_ff, pab_ff, 1'b1), pba_ff, 1'b1), {1'b0, qa_ff}, 1'b0);

   kaf_mul #(.SHW(6)) u_mul (.clock, .reset, .start(m_start), .a(m_a), .b(m_b),
                            .sh(m_sh), .done(m_done), .result(m_r));
   kaf_div #(.FRAC_BITS(FRAC_BITS)) u_div (.clock, .reset, .start(d_start), .n(d_n),
                                          .d(d_d), .done(d_done), .result(d_r));

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = out_ff;
   // load the output register once the previous beat has left or leaves now
   assign out_load = (st_ff == S_OUT) && (!vld_ff || rsp_tready);

   // operands for the step that is about to start
   always_comb begin
      m_start = 1'b0; m_a = dt_v; m_b = rate_ff; m_sh = SH_DT;
      d_start = 1'b0; d_n = paa_ff; d_d = s_val;
      case (st_ff)
         S_M1: begin m_start = 1'b1; end
         S_M2: begin m_start = 1'b1; m_b = pbb_ff; end
         S_M3: begin m_start = 1'b1; m_b = t_val; end
         S_M4: begin m_start = 1'b1; m_a = {1'b0, qb_ff}; m_b = dt_v; end
         S_D1: begin d_start = s_val != '0; end
         S_D2: begin d_start = s_val != '0; d_n = pba_ff; end
         S_M6: begin m_start = 1'b1; m_a = k0_ff; m_b = y_ff; m_sh = SH_FR; end
         S_M7: begin m_start = 1'b1; m_a = k1_ff; m_b = y_ff; m_sh = SH_FR; end
         S_M9: begin m_start = 1'b1; m_a = k0_ff; m_b = p00_ff; m_sh = SH_FR; end
         S_M10: begin m_start = 1'b1; m_a = k0_ff; m_b = p01_ff; m_sh = SH_FR; end
         S_M11: begin m_start = 1'b1; m_a = k1_ff; m_b = p00_ff; m_sh = SH_FR; end
         S_M12: begin m_start = 1'b1; m_a = k1_ff; m_b = p01_ff; m_sh = SH_FR; end
         default: begin end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; vld_ff <= 1'b0;
         qa_ff <= QA_RST; qb_ff <= QB_RST; rm_ff <= RM_RST;
         ang_ff <= '0; bias_ff <= '0; rate_ff <= '0;
         paa_ff <= '0; pab_ff <= '0; pba_ff <= '0; pbb_ff <= '0;
         ret_ff <= S_IDLE;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_QA: qa_ff <= csr_wdata;
               REG_QB: qb_ff <= csr_wdata;
               REG_RM: rm_ff <= csr_wdata;
               default: begin end
            endcase
         end
         vld_ff <= out_load || (vld_ff && !rsp_tready);
         case (st_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  meas_ff <= req_tdata[VW-1:0];
                  if (req_tuser == FUNC_SET) begin
                     ang_ff <= req_tdata[VW-1:0]; st_ff <= S_OUT;
                  end else begin
                     dt_ff <= req_tdata[2*VW+DW-1:2*VW];
                     rate_ff <= addsat(req_tdata[2*VW-1:VW], bias_ff, 1'b1);
                     st_ff <= S_M1;
                  end
               end
            end
            S_M1, S_M2, S_M3, S_M4, S_M6, S_M7, S_M9, S_M10, S_M11, S_M12: begin
               ret_ff <= st_ff; st_ff <= S_WAITM;
            end
            S_WAITM: begin
               if (m_done) begin
                  case (ret_ff)
                     S_M1: begin ang_ff <= addsat(ang_ff, m_r, 1'b0); st_ff <= S_M2; end
                     S_M2: begin d_ff <= m_r; st_ff <= S_M3; end
                     S_M3: begin
                        paa_ff <= addsat(paa_ff, m_r, 1'b0);
                        pab_ff <= addsat(pab_ff, d_ff, 1'b1);
                        pba_ff <= addsat(pba_ff, d_ff, 1'b1);
                        st_ff <= S_M4;
                     end
                     S_M4: begin pbb_ff <= addsat(pbb_ff, m_r, 1'b0); st_ff <= S_M5; end
                     S_M6: begin ang_ff <= addsat(ang_ff, m_r, 1'b0); st_ff <= S_M7; end
                     S_M7: begin bias_ff <= addsat(bias_ff, m_r, 1'b0); st_ff <= S_M8; end
                     S_M9: begin paa_ff <= addsat(paa_ff, m_r, 1'b1); st_ff <= S_M10; end
                     S_M10: begin pab_ff <= addsat(pab_ff, m_r, 1'b1); st_ff <= S_M11; end
                     S_M11: begin pba_ff <= addsat(pba_ff, m_r, 1'b1); st_ff <= S_M12; end
                     default: begin pbb_ff <= addsat(pbb_ff, m_r, 1'b1); st_ff <= S_OUT; end
                  endcase
               end
            end
            S_M5: begin
               k0_ff <= '0; k1_ff <= '0; st_ff <= S_D1;
            end
            S_D1, S_D2: begin
               ret_ff <= st_ff;
               // zero S: keep both gains at zero
               if (s_val == '0) st_ff <= S_M8;
               else st_ff <= S_WAITD;
            end
            S_WAITD: begin
               if (d_done) begin
                  if (ret_ff == S_D1) begin
                     k0_ff <= d_r; st_ff <= S_D2;
                  end else begin
                     k1_ff <= d_r; st_ff <= S_M8;
                  end
               end
            end
            S_M8: begin
               if (ret_ff == S_M7) begin
                  p00_ff <= paa_ff; p01_ff <= pab_ff; st_ff <= S_M9;
               end else begin
                  y_ff <= addsat(meas_ff, ang_ff, 1'b1); st_ff <= S_M6;
               end
            end
            S_OUT: begin
               if (out_load) begin
                  out_ff <= {rate_ff, ang_ff}; st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   `KAF_ASSERT(a_ready_idle, clock, reset, req_tready |-> st_ff == S_IDLE, "ready outside idle")
   `KAF_ASSERT(a_one_unit, clock, reset, !(m_start && d_start), "mul and div started together")
   `KAF_ASSERT(a_out_hold, clock, reset, (vld_ff && !rsp_tready) |=> $stable(rsp_tdata), "data moved")
   `KAF_ASSERT(a_valid_hold, clock, reset, (vld_ff && !rsp_tready) |=> vld_ff, "valid dropped")
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for kalman_angle_filter: random and directed angle/rate beats.
// Predicts each result with a fixed-point filter model; depends on kaf_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
   import kaf_pkg::*;

   typedef struct {
      logic        func;
      logic [47:0] meas_angle;
      logic [47:0] meas_rate;
      logic [31:0] dt;
   } sample_type;

   typedef struct {
      logic [47:0] angle;
      logic [47:0] rate;
   } estimate_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [CW-1:0] csr_wdata = '0;

   kalman_angle_filter dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   sample_type pending_samples[$];
   estimate_type expected_estimates[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit driver_hold = 0;

   // filter state
   longint q_angle, q_bias, r_meas;
   longint est_angle, est_bias, est_rate, p_aa, p_ab, p_ba, p_bb;
   localparam longint LIM_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint LIM_LO = -64'sh0000_8000_0000_0000;

   function automatic longint clamp48(longint v);
      if (v > LIM_HI) return LIM_HI;
      if (v < LIM_LO) return LIM_LO;
      return v;
   endfunction

   function automatic longint apply_sign(bit neg, logic [127:0] m);
      if (neg) return (m > 128'h8000_0000_0000) ? LIM_LO : -longint'(m);
      return (m > 128'h7FFF_FFFF_FFFF) ? LIM_HI : longint'(m);
   endfunction

   // product shifted right, rounded half away from zero
   function automatic longint fx_mul(longint a, longint b, int sh);
      logic [127:0] m;
      m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
      m = (m + (128'd1 << (sh - 1))) >> sh;
      return apply_sign((a < 0) != (b < 0), m);
   endfunction

   // (n << 32) / d truncated toward zero
   function automatic longint fx_div(longint n, longint d);
      logic [127:0] m;
      m = (128'(n < 0 ? -n : n) << 32) / 128'(d < 0 ? -d : d);
      return apply_sign((n < 0) != (d < 0), m);
   endfunction

   function automatic estimate_type filter_step(sample_type s);
      longint meas, dtv, d, t, sv, k0, k1, y, p00, p01;
      estimate_type r;
      meas = longint'($signed(s.meas_angle));
      if (s.func == FUNC_SET) begin
         est_angle = meas;
      end else begin
         dtv = longint'(s.dt);
         est_rate = clamp48(longint'($signed(s.meas_rate)) - est_bias);
         est_angle = clamp48(est_angle + fx_mul(dtv, est_rate, 32));
         d = fx_mul(dtv, p_bb, 32);
         t = clamp48(clamp48(clamp48(d - p_ab) - p_ba) + q_angle);
         p_aa = clamp48(p_aa + fx_mul(dtv, t, 32));
         p_ab = clamp48(p_ab - d);
         p_ba = clamp48(p_ba - d);
         p_bb = clamp48(p_bb + fx_mul(q_bias, dtv, 32));
         sv = clamp48(p_aa + r_meas);
         k0 = 0;
         k1 = 0;
         if (sv != 0) begin
            k0 = fx_div(p_aa, sv);
            k1 = fx_div(p_ba, sv);
         end
         y = clamp48(meas - est_angle);
         est_angle = clamp48(est_angle + fx_mul(k0, y, 32));
         est_bias = clamp48(est_bias + fx_mul(k1, y, 32));
         p00 = p_aa;
         p01 = p_ab;
         p_aa = clamp48(p_aa - fx_mul(k0, p00, 32));
         p_ab = clamp48(p_ab - fx_mul(k0, p01, 32));
         p_ba = clamp48(p_ba - fx_mul(k1, p00, 32));
         p_bb = clamp48(p_bb - fx_mul(k1, p01, 32));
      end
      r.angle = est_angle[47:0];
      r.rate = est_rate[47:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // driver: the head of the queue is the beat on the bus, drop it once accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid && req_tready) begin
            sample_type done;
            done = pending_samples.pop_front();
            expected_estimates.push_back(filter_step(done));
         end
         if (pending_samples.size() > 0 &&
             !driver_hold && $urandom_range(99) >= send_idle_pct) begin
            sample_type nx;
            nx = pending_samples[0];
            req_tvalid <= 1;
            req_tdata <= {nx.dt, nx.meas_rate, nx.meas_angle};
            req_tuser <= nx.func;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_estimates.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata[47:0], 48'h0);
            end else begin
               estimate_type e;
               e = expected_estimates.pop_front();
               if (rsp_tdata[47:0] !== e.angle)
                  report_mismatch("filtered_angle", rsp_tdata[47:0], e.angle);
               if (rsp_tdata[95:48] !== e.rate)
                  report_mismatch("unbiased_rate", rsp_tdata[95:48], e.rate);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   // mostly plausible IMU values, with some full-range noise
   function automatic sample_type rand_sample();
      sample_type s;
      int k;
      k = $urandom_range(99);
      s.func = ($urandom_range(99) < 8) ? FUNC_SET : FUNC_UPDATE;
      if (k < 80) begin
         s.meas_angle = 48'($signed(int'($urandom_range(360)) - 180)) << 32 | 48'($urandom());
         s.meas_rate = 48'($signed(int'($urandom_range(500)) - 250)) << 32 | 48'($urandom());
         s.dt = $urandom_range(50000000);
      end else begin
         s.meas_angle = rand48();
         s.meas_rate = rand48();
         s.dt = $urandom();
      end
      return s;
   endfunction

   function automatic sample_type mk(logic f, logic [47:0] a, logic [47:0] r, logic [31:0] d);
      sample_type s;
      s.func = f; s.meas_angle = a; s.meas_rate = r; s.dt = d;
      return s;
   endfunction

   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_tvalid || expected_estimates.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [CW-1:0] v);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         REG_QA: q_angle = longint'(v);
         REG_QB: q_bias = longint'(v);
         REG_RM: r_meas = longint'(v);
         default: ;
      endcase
   endtask

   task automatic run_random(int n, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (n) pending_samples.push_back(rand_sample());
      wait_drained();
   endtask

   initial begin
      q_angle = 4294967; q_bias = 12884902; r_meas = 128849019;
      est_angle = 0; est_bias = 0; est_rate = 0;
      p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      // S zero: covariance still zero after reset and every noise zeroed
      write_reg(REG_QA, '0);
      write_reg(REG_QB, '0);
      write_reg(REG_RM, '0);
      write_reg(2'd3, 47'h1234);
      pending_samples.push_back(mk(FUNC_UPDATE, 48'h0000_0001_0000_0000, 48'h0, 32'h0));
      pending_samples.push_back(mk(FUNC_UPDATE, 48'h0, 48'h0, 32'h0));
      wait_drained();
      write_reg(REG_QA, 47'd4294967);
      write_reg(REG_QB, 47'd12884902);
      write_reg(REG_RM, 47'd128849019);
      // directed: set extremes, a nominal update, update extremes, a zero update and a zero set
      pending_samples.push_back(mk(FUNC_SET, 48'h7FFF_FFFF_FFFF, 48'h0, 32'h0));
      pending_samples.push_back(mk(FUNC_SET, 48'h8000_0000_0000, 48'h0, 32'h0));
      pending_samples.push_back(mk(FUNC_UPDATE, 48'h0000_0005_0000_0000,
                                   48'h0000_000A_0000_0000, 32'd4294967));
      pending_samples.push_back(mk(FUNC_UPDATE, 48'h7FFF_FFFF_FFFF,
                                   48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF));
      pending_samples.push_back(mk(FUNC_UPDATE, 48'h8000_0000_0000,
                                   48'h8000_0000_0000, 32'hFFFF_FFFF));
      pending_samples.push_back(mk(FUNC_UPDATE, 48'h0, 48'h0, 32'h0));
      pending_samples.push_back(mk(FUNC_SET, 48'h0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
      wait_drained();
      write_reg(REG_QA, {CW{1'b1}});
      write_reg(REG_QB, {CW{1'b1}});
      write_reg(REG_RM, {CW{1'b1}});
      run_random(40, 0, 0);
      write_reg(REG_QA, 47'd4294967);
      write_reg(REG_QB, 47'd12884902);
      write_reg(REG_RM, 47'd128849019);
      run_random(260, 0, 0);
      run_random(180, 71, 0);
      // hold the sender with one sample queued, then release it and continue
      driver_hold = 1;
      pending_samples.push_back(rand_sample());
      repeat (30) @(posedge clock);
      driver_hold = 0;
      run_random(180, 0, 71);
      write_reg(REG_QA, 47'd429497);
      write_reg(REG_RM, 47'd4294967296);
      run_random(180, 11, 11);
      if (error_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

   initial begin
      #20000000;
      $display("tb: errors");
      $finish;
   end
endmodule
